// ===== src/tadcf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thermistor converter package
// Widths, fixed-point constants and status codes shared by the thermistor
// reading to Fahrenheit pipeline and its channel interfaces.
// ----------------------------------------------------------------------------
package tadcf_pkg;

    localparam int C_MAX_ADC_BITS = 16;
    localparam int C_MIN_ADC_BITS = 8;
    localparam int C_ADC_W        = 16;
    localparam int C_RES_W        = 5;
    localparam int C_TEMP_W       = 19;
    localparam int C_STATUS_W     = 2;

    localparam logic [C_RES_W-1:0] C_ADC_BITS_RESET = 5'd10;

    // Log2 in Q4.24: integer part is the top set bit index of a 16-bit value.
    localparam int C_K_W           = $clog2(C_ADC_W);
    localparam int C_LOG_FRAC_BITS = 24;
    localparam int C_LOG_W         = C_K_W + C_LOG_FRAC_BITS;
    localparam int C_LOG_LATENCY   = C_LOG_FRAC_BITS + 1;

    localparam logic [31:0] C_LN2_Q32  = 32'd2977044472;
    localparam logic [31:0] C_HALF_Q32 = 32'h8000_0000;

    // Steinhart-Hart coefficients in Q0.48.
    localparam logic [39:0] C_COEF_A    = 40'd944071406602;
    localparam logic [36:0] C_COEF_B    = 37'd72135632975;
    localparam logic [12:0] C_COEF_B_HI = C_COEF_B[36:24];
    localparam logic [23:0] C_COEF_B_LO = C_COEF_B[23:0];
    localparam logic [29:0] C_COEF_C    = 30'd586290140;
    localparam logic [24:0] C_COEF_D    = 25'd20548576;

    // 180 * 2^48 is the numerator of the kelvin to centi-Fahrenheit step.
    localparam logic [55:0] C_NUM_BASE = {8'd180, 48'd0};
    localparam int          C_DIV_BITS = 20;

    localparam logic signed [21:0] C_KELVIN_CF = 22'sd45967;
    localparam logic signed [C_TEMP_W-1:0] C_OUT_HIGH = 19'sd250000;
    localparam logic signed [C_TEMP_W-1:0] C_OUT_LOW  = -19'sd30000;

    typedef enum logic [C_STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_FULL = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

endpackage
`default_nettype wire

// ===== src/tadcf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thermistor converter channel interfaces
// Valid/ready channels for readings, results and the resolution register.
// ----------------------------------------------------------------------------
interface tadcf_in_if
    import tadcf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [C_ADC_W-1:0] adc_reading;

    modport source (output valid, output adc_reading, input ready);
    modport sink   (input valid, input adc_reading, output ready);
endinterface

interface tadcf_out_if
    import tadcf_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [C_TEMP_W-1:0] temperature_centi_f;
    logic [C_STATUS_W-1:0]      status;

    modport source (output valid, output temperature_centi_f, output status, input ready);
    modport sink   (input valid, input temperature_centi_f, input status, output ready);
endinterface

interface tadcf_cfg_if
    import tadcf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [C_RES_W-1:0] adc_resolution_bits;

    modport source (output valid, output adc_resolution_bits, input ready);
    modport sink   (input valid, input adc_resolution_bits, output ready);
endinterface
`default_nettype wire

// ===== src/tadcf_log2.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined base-2 logarithm
// Normalizes a 16-bit integer to Q1.31 and emits one fraction bit per stage
// by repeated squaring, giving log2 in Q4.24.
// ----------------------------------------------------------------------------
module tadcf_log2
    import tadcf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [C_ADC_W-1:0] i_x,
    output logic [C_LOG_W-1:0]      o_log2
);

    logic [C_K_W-1:0] w_k;
    logic [31:0]      w_y0;
    logic [31:0]      w_y_nxt [1:C_LOG_FRAC_BITS];
    logic             w_bit   [1:C_LOG_FRAC_BITS];

    logic [31:0]                r_y    [0:C_LOG_FRAC_BITS];
    logic [C_K_W-1:0]           r_k    [0:C_LOG_FRAC_BITS];
    logic [C_LOG_FRAC_BITS-1:0] r_frac [0:C_LOG_FRAC_BITS];

    // Top set bit index, then shift it up to bit 31.
    always_comb begin
        w_k = '0;
        for (int i = 1; i < C_ADC_W; i++) begin
            if (i_x[i]) begin
                w_k = C_K_W'(i);
            end
        end
        w_y0 = {i_x, 16'd0} << (C_K_W'(C_ADC_W - 1) - w_k);
    end

    always_comb begin
        logic [63:0] sq;
        logic [32:0] t;
        for (int j = 1; j <= C_LOG_FRAC_BITS; j++) begin
            sq         = 64'(r_y[j-1]) * 64'(r_y[j-1]);
            t          = sq[63:31];
            w_bit[j]   = t[32];
            w_y_nxt[j] = t[32] ? t[32:1] : t[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y[0]    <= w_y0;
            r_k[0]    <= w_k;
            r_frac[0] <= '0;
            for (int j = 1; j <= C_LOG_FRAC_BITS; j++) begin
                r_y[j]    <= w_y_nxt[j];
                r_k[j]    <= r_k[j-1];
                r_frac[j] <= {r_frac[j-1][C_LOG_FRAC_BITS-2:0], w_bit[j]};
            end
        end
    end

    assign o_log2 = {r_k[C_LOG_FRAC_BITS], r_frac[C_LOG_FRAC_BITS]};

endmodule
`default_nettype wire

// ===== src/thermistor_adc_to_fahrenheit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thermistor reading to Fahrenheit converter
// Cubic Steinhart-Hart conversion of a divider reading to 0.01 degF.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                         Meaning
//  i_cfg    in   adc_resolution_bits [4:0]       converter bits n
//  i_adc    in   adc_reading [15:0]              raw divider reading
//  o_temp   out  temperature_centi_f [18:0] s,   temperature, status code
//                status [1:0]
//
// The pipeline depth from acceptance to the output register is set by the
// two 24-stage squaring logarithms and the 20-stage restoring divider. A
// new item is accepted every cycle while the output register is not stalled.
// Reset clears all stage valid bits, sets the resolution to 10 bits and
// holds both input channels not ready.
// When the output register holds an item that is not taken, the whole
// pipeline holds and i_adc.ready drops in the same cycle.
// The resolution register is ready whenever reset is released and is written at any time outside reset.
//
module thermistor_adc_to_fahrenheit
    import tadcf_pkg::*;
#(
    parameter int MAX_ADC_BITS = C_MAX_ADC_BITS
)(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tadcf_cfg_if.sink   i_cfg,
    tadcf_in_if.sink    i_adc,
    tadcf_out_if.source o_temp
);

    // Stage numbering: 0..24 logarithms, then the arithmetic tail.
    localparam int S_LN   = C_LOG_LATENCY;
    localparam int S_SUB  = S_LN + 1;
    localparam int S_MUL1 = S_LN + 2;
    localparam int S_MUL2 = S_LN + 3;
    localparam int S_MUL3 = S_LN + 4;
    localparam int S_DEN  = S_LN + 5;
    localparam int S_DIV0 = S_LN + 6;
    localparam int S_OUT  = S_DIV0 + C_DIV_BITS + 1;
    localparam int NST    = S_OUT + 1;

    logic w_en;

    logic [C_RES_W-1:0] r_adc_bits;
    logic               r_vld [0:NST-1];
    t_status            r_pst [0:S_OUT-1];

    // ------------------------------------------------------------------
    // Entry: clamp the resolution, classify the reading, feed both logs.
    // ------------------------------------------------------------------
    logic [C_RES_W-1:0] w_n;
    logic [C_ADC_W:0]   w_full;
    logic [C_ADC_W-1:0] w_rest;
    t_status            w_pst;

    always_comb begin
        if (r_adc_bits < C_RES_W'(C_MIN_ADC_BITS)) begin
            w_n = C_RES_W'(C_MIN_ADC_BITS);
        end else if (r_adc_bits > C_RES_W'(MAX_ADC_BITS)) begin
            w_n = C_RES_W'(MAX_ADC_BITS);
        end else begin
            w_n = r_adc_bits;
        end
        w_full = (C_ADC_W+1)'(1) << w_n;
        w_rest = C_ADC_W'(w_full - {1'b0, i_adc.adc_reading});
        if (i_adc.adc_reading == '0) begin
            w_pst = ST_ZERO;
        end else if ({1'b0, i_adc.adc_reading} >= w_full) begin
            w_pst = ST_FULL;
        end else begin
            w_pst = ST_OK;
        end
    end

    logic [C_LOG_W-1:0] w_log_r;
    logic [C_LOG_W-1:0] w_log_f;

    tadcf_log2 u_log_r (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (i_adc.adc_reading),
        .o_log2 (w_log_r)
    );

    tadcf_log2 u_log_f (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (w_rest),
        .o_log2 (w_log_f)
    );

    // ------------------------------------------------------------------
    // Arithmetic tail. L = ln(r) - ln(F - r) is carried as sign and
    // magnitude, since every product truncates its magnitude toward zero.
    // Only the linear and cubic terms take the sign of L.
    // ------------------------------------------------------------------
    logic [C_LOG_W+31:0] w_p_r;
    logic [C_LOG_W+31:0] w_p_f;
    logic [C_LOG_W:0]    w_diff;
    logic [55:0]         w_mm;
    logic [51:0]         w_mbl;
    logic [59:0]         w_l3p;
    logic [61:0]         w_ctp;
    logic [60:0]         w_dtp;
    logic [42:0]         w_bd;
    logic signed [45:0]  w_den;

    logic [C_LOG_W-1:0] r_ln_r, r_ln_f;
    logic               r_neg1, r_neg2, r_neg3, r_neg4;
    logic [C_LOG_W-1:0] r_m1, r_m2;
    logic [31:0]        r_l2;
    logic [40:0]        r_pbh;
    logic [27:0]        r_pbl;
    logic [35:0]        r_l3;
    logic [37:0]        r_ct, r_ct3;
    logic [41:0]        r_bt, r_bt3;
    logic [36:0]        r_dt;
    logic signed [45:0] r_den;

    always_comb begin
        w_p_r  = (C_LOG_W+32)'(w_log_r) * (C_LOG_W+32)'(C_LN2_Q32)
                 + (C_LOG_W+32)'(C_HALF_Q32);
        w_p_f  = (C_LOG_W+32)'(w_log_f) * (C_LOG_W+32)'(C_LN2_Q32)
                 + (C_LOG_W+32)'(C_HALF_Q32);
        w_diff = {1'b0, r_ln_r} - {1'b0, r_ln_f};
        w_mm   = 56'(r_m1) * 56'(r_m1);
        w_mbl  = 52'(r_m1) * 52'(C_COEF_B_LO);
        w_l3p  = 60'(r_l2) * 60'(r_m2);
        w_ctp  = 62'(r_l2) * 62'(C_COEF_C);
        w_dtp  = 61'(r_l3) * 61'(C_COEF_D);
        w_bd   = 43'(r_bt3) + 43'(r_dt);
        w_den  = $signed(46'(C_COEF_A)) + $signed(46'(r_ct3))
                 + (r_neg4 ? -$signed(46'(w_bd)) : $signed(46'(w_bd)));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ln_r <= w_p_r[C_LOG_W+31:32];
            r_ln_f <= w_p_f[C_LOG_W+31:32];

            r_neg1 <= w_diff[C_LOG_W];
            r_m1   <= w_diff[C_LOG_W] ? C_LOG_W'(-w_diff) : w_diff[C_LOG_W-1:0];

            r_neg2 <= r_neg1;
            r_m2   <= r_m1;
            r_l2   <= w_mm[55:24];
            r_pbh  <= 41'(r_m1) * 41'(C_COEF_B_HI);
            r_pbl  <= w_mbl[51:24];

            r_neg3 <= r_neg2;
            r_l3   <= w_l3p[59:24];
            r_ct   <= w_ctp[61:24];
            r_bt   <= 42'(r_pbh) + 42'(r_pbl);

            r_neg4 <= r_neg3;
            r_dt   <= w_dtp[60:24];
            r_ct3  <= r_ct;
            r_bt3  <= r_bt;

            r_den  <= w_den;
        end
    end

    // ------------------------------------------------------------------
    // Divider: q = floor((180 * 2^48 + den/2) / den), one quotient bit a
    // stage. A quotient that needs more than 20 bits saturates high.
    // ------------------------------------------------------------------
    logic [43:0] w_dpos;
    logic [55:0] w_num;
    logic        w_den_bad;
    logic [55:0] w_rem_nxt [1:C_DIV_BITS];
    logic        w_qbit    [1:C_DIV_BITS];

    logic [55:0]           r_rem [0:C_DIV_BITS];
    logic [43:0]           r_dv  [0:C_DIV_BITS];
    logic [C_DIV_BITS-1:0] r_q   [0:C_DIV_BITS];

    always_comb begin
        w_dpos    = r_den[43:0];
        w_num     = C_NUM_BASE + 56'(w_dpos >> 1);
        w_den_bad = (r_den <= 46'sd0)
                    || (64'(w_num) >= (64'(w_dpos) << C_DIV_BITS));
    end

    always_comb begin
        logic [63:0] dsh;
        for (int i = 1; i <= C_DIV_BITS; i++) begin
            dsh          = 64'(r_dv[i-1]) << (C_DIV_BITS - i);
            w_qbit[i]    = 64'(r_rem[i-1]) >= dsh;
            w_rem_nxt[i] = w_qbit[i] ? 56'(64'(r_rem[i-1]) - dsh) : r_rem[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem[0] <= w_num;
            r_dv[0]  <= w_dpos;
            r_q[0]   <= '0;
            for (int i = 1; i <= C_DIV_BITS; i++) begin
                r_rem[i] <= w_rem_nxt[i];
                r_dv[i]  <= r_dv[i-1];
                r_q[i]   <= {r_q[i-1][C_DIV_BITS-2:0], w_qbit[i]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: remove the kelvin offset, clamp, and pick the status.
    // ------------------------------------------------------------------
    logic signed [21:0]         w_tq;
    logic signed [C_TEMP_W-1:0] w_temp;
    t_status                    w_status;

    logic signed [C_TEMP_W-1:0] r_temp;
    t_status                    r_status;

    always_comb begin
        w_tq = $signed({2'b00, r_q[C_DIV_BITS]}) - C_KELVIN_CF;
        case (r_pst[S_OUT-1])
            ST_ZERO: begin
                w_temp   = '0;
                w_status = ST_ZERO;
            end
            ST_FULL: begin
                w_temp   = '0;
                w_status = ST_FULL;
            end
            ST_SAT: begin
                w_temp   = C_OUT_HIGH;
                w_status = ST_SAT;
            end
            default: begin
                if (w_tq > 22'(C_OUT_HIGH)) begin
                    w_temp   = C_OUT_HIGH;
                    w_status = ST_SAT;
                end else if (w_tq < 22'(C_OUT_LOW)) begin
                    w_temp   = C_OUT_LOW;
                    w_status = ST_SAT;
                end else begin
                    w_temp   = C_TEMP_W'(w_tq);
                    w_status = ST_OK;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_temp   <= w_temp;
            r_status <= w_status;
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and status codes travel with the data.
    // ------------------------------------------------------------------
    assign w_en = !r_vld[S_OUT] || o_temp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_adc.valid;
            for (int s = 1; s < NST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // A bad denominator turns an ok item into a saturated one as it
    // enters the divider.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pst[0] <= w_pst;
            for (int s = 1; s < S_OUT; s++) begin
                if (s == S_DIV0 && r_pst[s-1] == ST_OK && w_den_bad) begin
                    r_pst[s] <= ST_SAT;
                end else begin
                    r_pst[s] <= r_pst[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_bits <= C_ADC_BITS_RESET;
        end else if (i_cfg.valid) begin
            r_adc_bits <= i_cfg.adc_resolution_bits;
        end
    end

    assign i_cfg.ready                = i_rst_n;
    assign i_adc.ready                = w_en && i_rst_n;
    assign o_temp.valid               = r_vld[S_OUT];
    assign o_temp.temperature_centi_f = r_temp;
    assign o_temp.status              = r_status;

`ifndef SYNTHESIS
    a_special_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_temp.valid && (r_status == ST_ZERO || r_status == ST_FULL))
        |-> (r_temp == '0))
        else $error("zero or full-scale item with nonzero temperature");

    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_temp.valid && r_status == ST_OK)
        |-> (r_temp <= C_OUT_HIGH && r_temp >= C_OUT_LOW))
        else $error("unsaturated item outside output range");

    a_sat_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_temp.valid && r_status == ST_SAT)
        |-> (r_temp == C_OUT_HIGH || r_temp == C_OUT_LOW))
        else $error("saturated item not at a bound");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[S_OUT] && !o_temp.ready) |=> (r_vld[S_OUT] && !i_adc.ready == !o_temp.ready))
        else $error("pipeline moved while output stalled");
`endif

endmodule
`default_nettype wire
